[hw/rtl/cfiht_pkg.sv]
// ----------------------------------------------------------------------------
// cfiht_pkg: shared types and constants of the feedback id hash table
// Holds the field widths, the action and status codes, the controller states
// and the command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package cfiht_pkg;

   // Default sizes of the table and of the owner range.
   localparam int TABLE_SLOTS_DEFAULT = 16;
   localparam int OWNER_COUNT_DEFAULT = 8;

   // Field widths.
   localparam int ACTION_W = 2;
   localparam int BUS_W    = 8;
   localparam int ID_W     = 11;
   localparam int OWNER_W  = 6;
   localparam int STATUS_W = 3;

   // The bus number is shifted by this much before it is folded into the id.
   localparam int BUS_SHIFT = 5;
   localparam int KEY_BITS  = BUS_W + BUS_SHIFT;

   // The home slot remainder takes a reciprocal multiply, a back multiply
   // with subtract, and one corrective subtract, in that order.
   localparam int HASH_STEPS = 3;
   localparam int HCNT_W     = 2;

   // Request action codes.
   typedef enum logic [ACTION_W-1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_LOOKUP = 2'd2
   } action_type;

   // Response status codes.
   typedef enum logic [STATUS_W-1:0] {
      RSP_CLEARED   = 3'd0,
      RSP_INSERTED  = 3'd1,
      RSP_DUPLICATE = 3'd2,
      RSP_REJECTED  = 3'd3,
      RSP_FULL      = 3'd4,
      RSP_HIT       = 3'd5,
      RSP_MISS      = 3'd6
   } rsp_status_type;

   // Controller states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_HASH,
      S_PRIME,
      S_PROBE,
      S_HOLD
   } ctrl_state_type;

   // One stored table entry.
   typedef struct packed {
      logic [BUS_W-1:0]   bus;
      logic [ID_W-1:0]    can_id;
      logic [OWNER_W-1:0] owner;
   } slot_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic           load_key;
      logic           clear_used;
      logic           hash_step;
      logic           prime;
      logic           probe_next;
      logic           write_slot;
      logic           set_res;
      logic           res_hit;
      rsp_status_type res_code;
      logic           load_rsp;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      action_type req_action;
      logic       req_insert_ok;
      logic       key_insert;
      logic       hash_done;
      logic       chk_used;
      logic       chk_match;
      logic       chk_last;
      logic       out_free;
   } dp_stat_type;

endpackage

[hw/rtl/cfiht_ram.sv]
// ----------------------------------------------------------------------------
// cfiht_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module cfiht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/cfiht_ctrl.sv]
// ----------------------------------------------------------------------------
// cfiht_ctrl: controller of the feedback id hash table
// Sequences one request through hashing, probing and the response hold.
// ----------------------------------------------------------------------------
module cfiht_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  cfiht_pkg::dp_stat_type  stat,
   output cfiht_pkg::dp_cmd_type   cmd
);

   cfiht_pkg::ctrl_state_type state_ff;
   cfiht_pkg::ctrl_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cfiht_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         cfiht_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_key = 1'b1;
               unique case (stat.req_action)
                  cfiht_pkg::ACT_CLEAR: begin
                     cmd.clear_used = 1'b1;
                     cmd.set_res    = 1'b1;
                     cmd.res_code   = cfiht_pkg::RSP_CLEARED;
                     state_in       = cfiht_pkg::S_HOLD;
                  end
                  cfiht_pkg::ACT_INSERT: begin
                     if (stat.req_insert_ok) begin
                        state_in = cfiht_pkg::S_HASH;
                     end else begin
                        cmd.set_res  = 1'b1;
                        cmd.res_code = cfiht_pkg::RSP_REJECTED;
                        state_in     = cfiht_pkg::S_HOLD;
                     end
                  end
                  cfiht_pkg::ACT_LOOKUP: begin
                     state_in = cfiht_pkg::S_HASH;
                  end
                  default: begin
                     cmd.set_res  = 1'b1;
                     cmd.res_code = cfiht_pkg::RSP_REJECTED;
                     state_in     = cfiht_pkg::S_HOLD;
                  end
               endcase
            end
         end
         cfiht_pkg::S_HASH: begin
            cmd.hash_step = 1'b1;
            if (stat.hash_done) begin
               state_in = cfiht_pkg::S_PRIME;
            end
         end
         cfiht_pkg::S_PRIME: begin
            cmd.prime = 1'b1;
            state_in  = cfiht_pkg::S_PROBE;
         end
         cfiht_pkg::S_PROBE: begin
            if (!stat.chk_used) begin
               // An empty slot ends the probe: fill it, or report a miss.
               cmd.set_res = 1'b1;
               if (stat.key_insert) begin
                  cmd.write_slot = 1'b1;
                  cmd.res_code   = cfiht_pkg::RSP_INSERTED;
               end else begin
                  cmd.res_code   = cfiht_pkg::RSP_MISS;
               end
               state_in = cfiht_pkg::S_HOLD;
            end else if (stat.chk_match) begin
               cmd.set_res = 1'b1;
               if (stat.key_insert) begin
                  cmd.res_code = cfiht_pkg::RSP_DUPLICATE;
               end else begin
                  cmd.res_hit  = 1'b1;
                  cmd.res_code = cfiht_pkg::RSP_HIT;
               end
               state_in = cfiht_pkg::S_HOLD;
            end else if (stat.chk_last) begin
               // A full pass found neither a free slot nor the key.
               cmd.set_res  = 1'b1;
               cmd.res_code = stat.key_insert ? cfiht_pkg::RSP_FULL : cfiht_pkg::RSP_MISS;
               state_in     = cfiht_pkg::S_HOLD;
            end else begin
               cmd.probe_next = 1'b1;
            end
         end
         cfiht_pkg::S_HOLD: begin
            if (stat.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = cfiht_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = cfiht_pkg::S_IDLE;
         end
      endcase
   end

endmodule

[hw/rtl/cfiht_dpath.sv]
// ----------------------------------------------------------------------------
// cfiht_dpath: datapath of the feedback id hash table
// Key registers, the home slot remainder by reciprocal multiplication, the
// probe address walk, the entry RAM with its valid bits, and the response
// register.
// ----------------------------------------------------------------------------
module cfiht_dpath #(
   parameter int TABLE_SLOTS = cfiht_pkg::TABLE_SLOTS_DEFAULT,
   parameter int OWNER_COUNT = cfiht_pkg::OWNER_COUNT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [cfiht_pkg::ACTION_W-1:0]    req_action,
   input  logic [cfiht_pkg::BUS_W-1:0]       req_bus,
   input  logic [cfiht_pkg::ID_W-1:0]        req_can_id,
   input  logic [cfiht_pkg::OWNER_W-1:0]     req_owner_index,
   input  logic                              req_eligible,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [cfiht_pkg::STATUS_W-1:0]    rsp_status,
   output logic [cfiht_pkg::OWNER_W-1:0]     rsp_found_owner,
   input  cfiht_pkg::dp_cmd_type             cmd,
   output cfiht_pkg::dp_stat_type            stat
);

   localparam int AW = $clog2(TABLE_SLOTS);
   localparam int KB = cfiht_pkg::KEY_BITS;
   localparam int HW = cfiht_pkg::HCNT_W;
   localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_SLOTS - 1);
   localparam logic [KB-1:0] SLOTS_KB  = KB'(TABLE_SLOTS);
   // Rounded-down reciprocal; the quotient estimate is short by at most one.
   localparam logic [KB-1:0] RECIP     = KB'((1 << KB) / TABLE_SLOTS);

   // Key of the request in work.
   logic [cfiht_pkg::BUS_W-1:0]   key_bus_ff, key_bus_in;
   logic [cfiht_pkg::ID_W-1:0]    key_id_ff, key_id_in;
   logic [cfiht_pkg::OWNER_W-1:0] key_owner_ff, key_owner_in;
   logic                          key_insert_ff, key_insert_in;

   // Home slot remainder unit.
   logic [KB-1:0]   hkey_ff, hkey_in;
   logic [HW-1:0]   hcnt_ff, hcnt_in;
   logic [KB-1:0]   quot_ff, quot_in;
   logic [KB-1:0]   diff_ff, diff_in;
   logic [AW-1:0]   rem_ff, rem_in;
   logic [2*KB-1:0] hprod;

   // Probe walk.
   logic [AW-1:0] probe_addr_ff, probe_addr_in;
   logic [AW-1:0] chk_addr_ff, chk_addr_in;
   logic [AW-1:0] k_ff, k_in;
   logic [AW-1:0] home;
   logic [AW-1:0] ram_rd_addr;

   // Valid bits of the table entries.
   logic [TABLE_SLOTS-1:0] used_ff, used_in;

   // Staged result and response register.
   cfiht_pkg::rsp_status_type     res_status_ff, res_status_in;
   logic [cfiht_pkg::OWNER_W-1:0] res_owner_ff, res_owner_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [cfiht_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [cfiht_pkg::OWNER_W-1:0] rsp_owner_ff, rsp_owner_in;

   // Entry RAM.
   logic [$bits(cfiht_pkg::slot_type)-1:0] ram_rd_data;
   cfiht_pkg::slot_type                    rd_slot;
   cfiht_pkg::slot_type                    wr_slot;

   assign wr_slot.bus    = key_bus_ff;
   assign wr_slot.can_id = key_id_ff;
   assign wr_slot.owner  = key_owner_ff;
   assign rd_slot        = cfiht_pkg::slot_type'(ram_rd_data);

   cfiht_ram #(
      .WIDTH ($bits(cfiht_pkg::slot_type)),
      .DEPTH (TABLE_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (cmd.write_slot),
      .wr_addr (chk_addr_ff),
      .wr_data (wr_slot),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Key times the reciprocal; the upper half is the quotient estimate.
   assign hprod = {{KB{1'b0}}, hkey_ff} * {{KB{1'b0}}, RECIP};
   assign home  = rem_ff;

   // The first read goes to the home slot, later reads walk on.
   assign ram_rd_addr = cmd.prime ? home : probe_addr_ff;

   // Next values of the datapath registers.
   always_comb begin
      key_bus_in    = key_bus_ff;
      key_id_in     = key_id_ff;
      key_owner_in  = key_owner_ff;
      key_insert_in = key_insert_ff;
      hkey_in       = hkey_ff;
      hcnt_in       = hcnt_ff;
      quot_in       = quot_ff;
      diff_in       = diff_ff;
      rem_in        = rem_ff;
      probe_addr_in = probe_addr_ff;
      chk_addr_in   = chk_addr_ff;
      k_in          = k_ff;
      used_in       = used_ff;
      res_status_in = res_status_ff;
      res_owner_in  = res_owner_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_owner_in  = rsp_owner_ff;

      if (cmd.load_key) begin
         key_bus_in    = req_bus;
         key_id_in     = req_can_id;
         key_owner_in  = req_owner_index;
         key_insert_in = (cfiht_pkg::action_type'(req_action) == cfiht_pkg::ACT_INSERT);
         hkey_in       = KB'(req_can_id) ^ {req_bus, {cfiht_pkg::BUS_SHIFT{1'b0}}};
         hcnt_in       = '0;
         rem_in        = '0;
      end

      // Three-stage remainder: quotient estimate, back subtract, correction.
      if (cmd.hash_step) begin
         hcnt_in = hcnt_ff + 1'b1;
         quot_in = KB'(hprod >> KB);
         diff_in = hkey_ff - quot_ff * SLOTS_KB;
         rem_in  = (diff_ff >= SLOTS_KB) ? AW'(diff_ff - SLOTS_KB) : AW'(diff_ff);
      end

      if (cmd.prime) begin
         chk_addr_in   = home;
         probe_addr_in = (home == LAST_SLOT) ? '0 : home + 1'b1;
         k_in          = '0;
      end

      if (cmd.probe_next) begin
         chk_addr_in   = probe_addr_ff;
         probe_addr_in = (probe_addr_ff == LAST_SLOT) ? '0 : probe_addr_ff + 1'b1;
         k_in          = k_ff + 1'b1;
      end

      if (cmd.clear_used) begin
         used_in = '0;
      end
      if (cmd.write_slot) begin
         used_in[chk_addr_ff] = 1'b1;
      end

      if (cmd.set_res) begin
         res_status_in = cmd.res_code;
         res_owner_in  = cmd.res_hit ? rd_slot.owner : '0;
      end

      // The response register drains on an accepted beat and refills on load.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_owner_in  = res_owner_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      key_bus_ff    <= key_bus_in;
      key_id_ff     <= key_id_in;
      key_owner_ff  <= key_owner_in;
      key_insert_ff <= key_insert_in;
      hkey_ff       <= hkey_in;
      hcnt_ff       <= hcnt_in;
      quot_ff       <= quot_in;
      diff_ff       <= diff_in;
      rem_ff        <= rem_in;
      probe_addr_ff <= probe_addr_in;
      chk_addr_ff   <= chk_addr_in;
      k_ff          <= k_in;
      res_status_ff <= res_status_in;
      res_owner_ff  <= res_owner_in;
      rsp_status_ff <= rsp_status_in;
      rsp_owner_ff  <= rsp_owner_in;
   end

   // Status back to the controller.
   always_comb begin
      stat.req_action    = cfiht_pkg::action_type'(req_action);
      stat.req_insert_ok = req_eligible && (req_bus != '0) &&
                           ({1'b0, req_owner_index} <
                            (cfiht_pkg::OWNER_W + 1)'(OWNER_COUNT));
      stat.key_insert    = key_insert_ff;
      stat.hash_done     = (hcnt_ff == HW'(cfiht_pkg::HASH_STEPS - 1));
      stat.chk_used      = used_ff[chk_addr_ff];
      stat.chk_match     = (rd_slot.bus == key_bus_ff) && (rd_slot.can_id == key_id_ff);
      stat.chk_last      = (k_ff == LAST_SLOT);
      stat.out_free      = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_owner = rsp_owner_ff;

   // A slot is only ever filled while it is empty.
   a_write_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.write_slot |-> !used_ff[chk_addr_ff])
      else $error("insert wrote a slot that was already in use");

   // A filled slot reads as used on the next cycle.
   a_write_marks: assert property (@(posedge clock) disable iff (reset)
      cmd.write_slot |=> used_ff[$past(chk_addr_ff)])
      else $error("filled slot not marked as used");

   // The probe never walks past one full pass.
   a_probe_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.probe_next |-> (k_ff != LAST_SLOT))
      else $error("probe went beyond one pass of the table");

   // A new response never overwrites one that is still stalled.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !(rsp_valid_ff && rsp_stall))
      else $error("response register overwritten while stalled");

endmodule

[hw/rtl/can_feedback_id_hash_table.sv]
// ----------------------------------------------------------------------------
// can_feedback_id_hash_table: CAN feedback id to owner hash table
// Open-addressing table keyed by (bus, standard id) with linear probing.
// Each request clears the table, inserts a key or looks one up.
//
//   Channel  Direction  Handshake               Payload
//   req      in         req_valid / req_stall   action, bus, can_id,
//                                               owner_index, eligible
//   rsp      out        rsp_valid / rsp_stall   status, found_owner
//
// A clear, a refused insert or an unused action sets its result at the request
// beat and reaches the response register from the hold state. An insert or a
// lookup loads its key, forms the home slot remainder (reciprocal multiply,
// back multiply and subtract, one correction), primes a read of the home slot
// and probes P slots (1 to TABLE_SLOTS), one slot a cycle through the entry
// RAM read port, before its result reaches the response register.
// Reset clears the controller, the response valid and all slot valid bits;
// the entry RAM is not cleared and is only read under a valid bit.
// A stalled response holds in its register; the next request beat is taken
// as soon as the previous result has moved into that register.
// ----------------------------------------------------------------------------
module can_feedback_id_hash_table #(
   parameter int TABLE_SLOTS = cfiht_pkg::TABLE_SLOTS_DEFAULT,
   parameter int OWNER_COUNT = cfiht_pkg::OWNER_COUNT_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [cfiht_pkg::ACTION_W-1:0] req_action,
   input  logic [cfiht_pkg::BUS_W-1:0]    req_bus,
   input  logic [cfiht_pkg::ID_W-1:0]     req_can_id,
   input  logic [cfiht_pkg::OWNER_W-1:0]  req_owner_index,
   input  logic                           req_eligible,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [cfiht_pkg::STATUS_W-1:0] rsp_status,
   output logic [cfiht_pkg::OWNER_W-1:0]  rsp_found_owner
);

   cfiht_pkg::dp_cmd_type  cmd;
   cfiht_pkg::dp_stat_type stat;

   // Request sequencing.
   cfiht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Table storage, hashing and response register.
   cfiht_dpath #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .OWNER_COUNT (OWNER_COUNT)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_action      (req_action),
      .req_bus         (req_bus),
      .req_can_id      (req_can_id),
      .req_owner_index (req_owner_index),
      .req_eligible    (req_eligible),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_found_owner (rsp_found_owner),
      .cmd             (cmd),
      .stat            (stat)
   );

endmodule
